[design/planar_pose_residual_assert.svh]
// Assertion macros for the planar pose residual block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef PLANAR_POSE_RESIDUAL_ASSERT_SVH
`define PLANAR_POSE_RESIDUAL_ASSERT_SVH
`ifndef SYNTHESIS
`define PPR_CHECK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ppr: check failed");
`define PPR_CHECK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppr: implication failed");
`else
`define PPR_CHECK(lbl, prop)
`define PPR_CHECK_IMP(lbl, ante, cons)
`endif
`endif

[design/ppr_pkg.sv]
// Shared types, constants and rounding and saturation helpers for the planar pose residual.
// No dependencies.
`timescale 1ns / 1ps

package ppr_pkg;

    localparam int ANGLE_FRAC_BITS = 28;
    localparam int ANG_SHIFT       = 30 - ANGLE_FRAC_BITS;
    localparam int N_CELLS         = 6;

    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [32:0] PI_ANG =
        33'((PI_Q30 + (36'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> ANG_SHIFT);
    localparam logic signed [32:0] TWO_PI_ANG =
        33'((TWO_PI_Q30 + (36'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> ANG_SHIFT);

    localparam logic [30:0] SER_ONE = 31'h4000_0000;
    localparam logic signed [31:0] TRIG_ONE = 32'sh4000_0000;

    // quadrant codes from range reduction
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // register indexes
    localparam logic [1:0] REG_EXT_X   = 2'd0;
    localparam logic [1:0] REG_EXT_Y   = 2'd1;
    localparam logic [1:0] REG_EXT_YAW = 2'd2;

    typedef logic [29:0] x2_t;   // r^2 in Q0.30, never negative
    typedef logic [30:0] ser_t;  // series value in Q1.30, 0 .. 1.0

    // constant divisor: q = (m * recip) >> sh, then one correction step
    typedef struct packed {
        logic [7:0]  d;
        logic [30:0] recip;
        logic [5:0]  sh;
    } div_k_t;

    // first sine step sees a zero series value; its divisor is a don't-care
    localparam div_k_t SIN_K [N_CELLS] = '{
        '{8'd2,   31'((64'd1 << 31) / 64'd2),   6'd31},
        '{8'd110, 31'((64'd1 << 36) / 64'd110), 6'd36},
        '{8'd72,  31'((64'd1 << 36) / 64'd72),  6'd36},
        '{8'd42,  31'((64'd1 << 35) / 64'd42),  6'd35},
        '{8'd20,  31'((64'd1 << 34) / 64'd20),  6'd34},
        '{8'd6,   31'((64'd1 << 32) / 64'd6),   6'd32}
    };
    localparam div_k_t COS_K [N_CELLS] = '{
        '{8'd132, 31'((64'd1 << 37) / 64'd132), 6'd37},
        '{8'd90,  31'((64'd1 << 36) / 64'd90),  6'd36},
        '{8'd56,  31'((64'd1 << 35) / 64'd56),  6'd35},
        '{8'd30,  31'((64'd1 << 34) / 64'd30),  6'd34},
        '{8'd12,  31'((64'd1 << 33) / 64'd12),  6'd33},
        '{8'd2,   31'((64'd1 << 31) / 64'd2),   6'd31}
    };

    // product / 2^30, nearest, ties away from zero
    function automatic logic signed [37:0] rnd30(input logic signed [67:0] p);
        logic signed [67:0] s;
        begin
            s = p + ((p < 0) ? 68'sd536870911 : 68'sd536870912);
            rnd30 = 38'(s >>> 30);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        begin
            if (v > 40'sd2147483647)
                sat32 = 32'sh7fff_ffff;
            else if (v < -40'sd2147483648)
                sat32 = 32'sh8000_0000;
            else
                sat32 = 32'(v);
        end
    endfunction

endpackage

[design/ppr_cell.sv]
// One Horner step of the sine/cosine series for two angles (four lanes).
// Depends on ppr_pkg. Three register stages: multiply, round and scale, correct.
`timescale 1ns / 1ps

module ppr_cell (
    input  logic            clk,
    input  ppr_pkg::x2_t    x2_in  [2],
    input  ppr_pkg::ser_t   v_in   [4],
    input  ppr_pkg::div_k_t k_sin,
    input  ppr_pkg::div_k_t k_cos,
    output ppr_pkg::x2_t    x2_out [2],
    output ppr_pkg::ser_t   v_out  [4]
);
    import ppr_pkg::*;

    // lanes: 0 sin ext, 1 cos ext, 2 sin odom, 3 cos odom
    logic [60:0] p_reg  [4];
    logic [60:0] p_next [4];
    logic [29:0] m_reg  [4];
    logic [29:0] m_next [4];
    logic [60:0] t_reg  [4];
    logic [60:0] t_next [4];
    ser_t        v_reg  [4];
    ser_t        v_next [4];
    x2_t         x2a_reg [2];
    x2_t         x2b_reg [2];
    x2_t         x2c_reg [2];

    always_comb
    begin
        div_k_t      k;
        logic [30:0] q0;
        logic [38:0] qd;
        logic [39:0] rem;
        logic [30:0] qv;
        for (int l = 0; l < 4; l++)
        begin
            k = l[0] ? k_cos : k_sin;
            p_next[l] = 61'(x2_in[l >> 1]) * 61'(v_in[l]);
            m_next[l] = 30'((p_reg[l] + 61'd536870912) >> 30);
            t_next[l] = 61'(m_next[l]) * 61'(k.recip);
            q0 = 31'(t_reg[l] >> k.sh);
            qd = 39'(q0) * 39'(k.d);
            rem = 40'(m_reg[l]) - 40'(qd);
            // estimate is low by at most one
            qv = q0 + 31'(rem >= 40'(k.d));
            v_next[l] = SER_ONE - qv;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        m_reg   <= m_next;
        t_reg   <= t_next;
        v_reg   <= v_next;
        x2a_reg <= x2_in;
        x2b_reg <= x2a_reg;
        x2c_reg <= x2b_reg;
    end

    assign v_out  = v_reg;
    assign x2_out = x2c_reg;

endmodule

[design/planar_pose_residual.sv]
// Top level of the SE(2) pose composition residual; holds range reduction,
// the series chain of ppr_cell, the rotation stages and the output registers.
// Depends on ppr_pkg, ppr_cell and planar_pose_residual_assert.svh.
`timescale 1ns / 1ps
`include "planar_pose_residual_assert.svh"

// One item is taken per clock whenever start is high and busy is low; busy is
// high only in the first cycle after reset. Each result is on the outputs for
// one cycle with done high; the receiver cannot stall it. Each item passes
// through range reduction, the six-cell sine/cosine chain and two rounds
// of rotation products. Extrinsic registers may be written only while no
// item is in flight.
module planar_pose_residual (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic signed [31:0] odom_x,
    input  logic signed [31:0] odom_y,
    input  logic signed [30:0] odom_yaw,
    input  logic signed [31:0] scan_x,
    input  logic signed [31:0] scan_y,
    input  logic signed [30:0] scan_yaw,
    output logic signed [31:0] err_x,
    output logic signed [31:0] err_y,
    output logic signed [31:0] err_yaw,
    output logic signed [31:0] pred_x,
    output logic signed [31:0] pred_y,
    output logic signed [30:0] pred_yaw,
    output logic signed [31:0] scan_err_x,
    output logic signed [31:0] scan_err_y,
    output logic signed [31:0] scan_err_yaw
);
    import ppr_pkg::*;

    localparam int LAT      = 28;
    localparam int SIDE_LEN = 27;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [30:0] ot;
        logic signed [30:0] st;
        logic signed [30:0] r_l;
        logic signed [30:0] r_o;
        logic [1:0]         q_l;
        logic [1:0]         q_o;
    } side_t;

    typedef struct packed {
        logic signed [30:0] r;
        logic [1:0]         q;
    } red_t;

    function automatic red_t reduce(input logic signed [30:0] ang);
        logic signed [34:0] a;
        logic signed [34:0] n;
        logic [2:0]         cnt;
        logic signed [2:0]  q;
        red_t               res;
        begin
            a = 35'(ang) <<< ANG_SHIFT;
            n = a + 35'(HALF_PI_Q30 >>> 1);
            cnt = 3'd0;
            for (int k = -2; k <= 3; k++)
                cnt = cnt + 3'(n >= 35'(k) * 35'(HALF_PI_Q30));
            q = 3'(cnt) - 3'sd3;
            res.r = 31'(a - 35'(q) * 35'(HALF_PI_Q30));
            res.q = q[1:0];
            reduce = res;
        end
    endfunction

    // config and control
    logic signed [31:0] ext_x_reg, ext_x_next;
    logic signed [31:0] ext_y_reg, ext_y_next;
    logic signed [30:0] ext_yaw_reg, ext_yaw_next;
    logic               busy_reg, busy_next;
    logic [LAT:1]       vld_reg, vld_next;
    logic               accept;

    // datapath
    side_t              side_reg [SIDE_LEN];
    logic signed [61:0] rr_reg [2];
    x2_t                x2_0_reg [2];
    x2_t                x2_ch [N_CELLS + 1][2];
    ser_t               v_ch  [N_CELLS + 1][4];
    logic signed [62:0] sp_reg [2];
    ser_t               ca_reg [2];
    logic signed [31:0] sl_reg, cl_reg, so_reg, co_reg;
    logic signed [63:0] m_clsx, m_slsy, m_slsx, m_clsy;
    logic signed [63:0] m_colx, m_soly, m_solx, m_coly;
    logic signed [63:0] m_cllx, m_slly, m_sllx, m_clly;
    logic signed [35:0] olx_reg, oly_reg, ilx_reg, ily_reg;
    logic signed [37:0] ex_reg, ey_reg, ex2_reg, ey2_reg;
    logic signed [31:0] cl1_reg, sl1_reg;
    logic signed [31:0] cl2_reg, sl2_reg;
    logic signed [67:0] n_clox, n_sloy, n_slox, n_cloy;
    logic signed [35:0] ilx2_reg, ily2_reg;
    logic signed [39:0] px_reg, py_reg;
    logic signed [37:0] ex3_reg, ey3_reg;

    logic signed [31:0] err_x_reg, err_y_reg, err_yaw_reg;
    logic signed [31:0] pred_x_reg, pred_y_reg;
    logic signed [30:0] pred_yaw_reg;
    logic signed [31:0] scan_err_x_reg, scan_err_y_reg, scan_err_yaw_reg;

    assign accept = start && !busy_reg;

    always_comb
    begin
        ext_x_next   = ext_x_reg;
        ext_y_next   = ext_y_reg;
        ext_yaw_next = ext_yaw_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_EXT_X:   ext_x_next   = cfg_wdata;
                REG_EXT_Y:   ext_y_next   = cfg_wdata;
                REG_EXT_YAW: ext_yaw_next = cfg_wdata[30:0];
                default:     ;
            endcase
        end
        busy_next = 1'b0;
        vld_next  = {vld_reg[LAT-1:1], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_x_reg   <= '0;
            ext_y_reg   <= '0;
            ext_yaw_reg <= '0;
            busy_reg    <= 1'b1;
            vld_reg     <= '0;
        end
        else
        begin
            ext_x_reg   <= ext_x_next;
            ext_y_reg   <= ext_y_next;
            ext_yaw_reg <= ext_yaw_next;
            busy_reg    <= busy_next;
            vld_reg     <= vld_next;
        end
    end

    // range reduction and r^2
    always_ff @(posedge clk)
    begin
        red_t rl;
        red_t ro;
        rl = reduce(ext_yaw_reg);
        ro = reduce(odom_yaw);
        side_reg[0] <= '{odom_x, odom_y, scan_x, scan_y, odom_yaw, scan_yaw,
                         rl.r, ro.r, rl.q, ro.q};
        for (int i = 1; i < SIDE_LEN; i++)
            side_reg[i] <= side_reg[i-1];
        rr_reg[0] <= 62'(side_reg[0].r_l) * 62'(side_reg[0].r_l);
        rr_reg[1] <= 62'(side_reg[0].r_o) * 62'(side_reg[0].r_o);
        x2_0_reg[0] <= 30'(rnd30(68'(rr_reg[0])));
        x2_0_reg[1] <= 30'(rnd30(68'(rr_reg[1])));
    end

    assign x2_ch[0] = x2_0_reg;

    // sine lanes start from zero so their first step yields one
    assign v_ch[0][0] = '0;
    assign v_ch[0][1] = SER_ONE;
    assign v_ch[0][2] = '0;
    assign v_ch[0][3] = SER_ONE;

    for (genvar g = 0; g < N_CELLS; g++)
    begin : g_cell
        ppr_cell u_cell (
            .clk    (clk),
            .x2_in  (x2_ch[g]),
            .v_in   (v_ch[g]),
            .k_sin  (SIN_K[g]),
            .k_cos  (COS_K[g]),
            .x2_out (x2_ch[g+1]),
            .v_out  (v_ch[g+1])
        );
    end

    // sine = r * series, quadrant fold, rotations
    always_ff @(posedge clk)
    begin
        logic signed [31:0] s_l, s_o, c_l, c_o;
        logic signed [36:0] lsx, lsy, olx, oly;
        s_l = 32'(rnd30(68'(sp_reg[0])));
        s_o = 32'(rnd30(68'(sp_reg[1])));
        c_l = signed'({1'b0, ca_reg[0]});
        c_o = signed'({1'b0, ca_reg[1]});

        sp_reg[0] <= 63'(side_reg[20].r_l) * 63'(signed'({1'b0, v_ch[N_CELLS][0]}));
        sp_reg[1] <= 63'(side_reg[20].r_o) * 63'(signed'({1'b0, v_ch[N_CELLS][2]}));
        ca_reg[0] <= v_ch[N_CELLS][1];
        ca_reg[1] <= v_ch[N_CELLS][3];

        case (side_reg[21].q_l)
            QUAD_0:  begin sl_reg <= s_l;  cl_reg <= c_l;  end
            QUAD_1:  begin sl_reg <= c_l;  cl_reg <= -s_l; end
            QUAD_2:  begin sl_reg <= -s_l; cl_reg <= -c_l; end
            default: begin sl_reg <= -c_l; cl_reg <= s_l;  end
        endcase
        case (side_reg[21].q_o)
            QUAD_0:  begin so_reg <= s_o;  co_reg <= c_o;  end
            QUAD_1:  begin so_reg <= c_o;  co_reg <= -s_o; end
            QUAD_2:  begin so_reg <= -s_o; co_reg <= -c_o; end
            default: begin so_reg <= -c_o; co_reg <= s_o;  end
        endcase

        m_clsx <= 64'(cl_reg) * 64'(side_reg[22].sx);
        m_slsy <= 64'(sl_reg) * 64'(side_reg[22].sy);
        m_slsx <= 64'(sl_reg) * 64'(side_reg[22].sx);
        m_clsy <= 64'(cl_reg) * 64'(side_reg[22].sy);
        m_colx <= 64'(co_reg) * 64'(ext_x_reg);
        m_soly <= 64'(so_reg) * 64'(ext_y_reg);
        m_solx <= 64'(so_reg) * 64'(ext_x_reg);
        m_coly <= 64'(co_reg) * 64'(ext_y_reg);
        m_cllx <= 64'(cl_reg) * 64'(ext_x_reg);
        m_slly <= 64'(sl_reg) * 64'(ext_y_reg);
        m_sllx <= 64'(sl_reg) * 64'(ext_x_reg);
        m_clly <= 64'(cl_reg) * 64'(ext_y_reg);
        cl1_reg <= cl_reg;
        sl1_reg <= sl_reg;

        lsx = 37'(ext_x_reg) + 37'(rnd30(68'(m_clsx))) - 37'(rnd30(68'(m_slsy)));
        lsy = 37'(ext_y_reg) + 37'(rnd30(68'(m_slsx))) + 37'(rnd30(68'(m_clsy)));
        olx = 37'(side_reg[23].ox) + 37'(rnd30(68'(m_colx))) - 37'(rnd30(68'(m_soly)));
        oly = 37'(side_reg[23].oy) + 37'(rnd30(68'(m_solx))) + 37'(rnd30(68'(m_coly)));
        olx_reg <= 36'(olx);
        oly_reg <= 36'(oly);
        ex_reg  <= 38'(lsx) - 38'(olx);
        ey_reg  <= 38'(lsy) - 38'(oly);
        ilx_reg <= 36'(-(37'(rnd30(68'(m_cllx))) + 37'(rnd30(68'(m_slly)))));
        ily_reg <= 36'(37'(rnd30(68'(m_sllx))) - 37'(rnd30(68'(m_clly))));
        cl2_reg <= cl1_reg;
        sl2_reg <= sl1_reg;

        n_clox   <= 68'(cl2_reg) * 68'(olx_reg);
        n_sloy   <= 68'(sl2_reg) * 68'(oly_reg);
        n_slox   <= 68'(sl2_reg) * 68'(olx_reg);
        n_cloy   <= 68'(cl2_reg) * 68'(oly_reg);
        ilx2_reg <= ilx_reg;
        ily2_reg <= ily_reg;
        ex2_reg  <= ex_reg;
        ey2_reg  <= ey_reg;

        px_reg  <= 40'(ilx2_reg) + 40'(rnd30(n_clox)) + 40'(rnd30(n_sloy));
        py_reg  <= 40'(ily2_reg) - 40'(rnd30(n_slox)) + 40'(rnd30(n_cloy));
        ex3_reg <= ex2_reg;
        ey3_reg <= ey2_reg;
    end

    // output beat
    always_ff @(posedge clk)
    begin
        logic signed [32:0] t;
        logic signed [32:0] pt;
        t = 33'(side_reg[26].ot);
        if (t > PI_ANG)
            pt = t - TWO_PI_ANG;
        else if (t < -PI_ANG)
            pt = t + TWO_PI_ANG;
        else
            pt = t;
        err_x_reg        <= sat32(40'(ex3_reg));
        err_y_reg        <= sat32(40'(ey3_reg));
        err_yaw_reg      <= 32'(side_reg[26].st) - 32'(side_reg[26].ot);
        pred_x_reg       <= sat32(px_reg);
        pred_y_reg       <= sat32(py_reg);
        pred_yaw_reg     <= 31'(pt);
        scan_err_x_reg   <= sat32(px_reg - 40'(side_reg[26].sx));
        scan_err_y_reg   <= sat32(py_reg - 40'(side_reg[26].sy));
        scan_err_yaw_reg <= 32'(pt) - 32'(side_reg[26].st);
    end

    assign busy         = busy_reg;
    assign done         = vld_reg[LAT];
    assign err_x        = err_x_reg;
    assign err_y        = err_y_reg;
    assign err_yaw      = err_yaw_reg;
    assign pred_x       = pred_x_reg;
    assign pred_y       = pred_y_reg;
    assign pred_yaw     = pred_yaw_reg;
    assign scan_err_x   = scan_err_x_reg;
    assign scan_err_y   = scan_err_y_reg;
    assign scan_err_yaw = scan_err_yaw_reg;

    `PPR_CHECK(a_done_latency, done |-> $past(start && !busy, LAT))
    `PPR_CHECK_IMP(a_pred_yaw_wrapped, done, (33'(pred_yaw) <= PI_ANG && 33'(pred_yaw) >= -PI_ANG))
    `PPR_CHECK_IMP(a_trig_bounded, vld_reg[23], (cl_reg <= TRIG_ONE && cl_reg >= -TRIG_ONE))

endmodule

[tb/testbench.sv]
// Self-checking testbench for planar_pose_residual: drives pose pairs,
// predicts each residual beat and compares it field by field.
// Depends on ppr_pkg and the planar_pose_residual RTL.
`timescale 1ns / 1ps

module testbench;
    import ppr_pkg::*;

    localparam longint HALF_PI_FX = 64'sd1686629713;   // pi/2 in Q2.30
    localparam longint PI_FX      = 64'sd3373259426;
    localparam longint TWO_PI_FX  = 64'sd6746518852;
    localparam int     AFB        = 28;
    localparam int     YAW_MAX    = 843314857;
    localparam int     DRAIN      = 40;
    localparam int     LIMIT      = 600000;

    typedef struct {
        logic signed [31:0] ox, oy, sx, sy;
        logic signed [30:0] ot, st;
    } pose_pair_t;

    typedef struct {
        logic signed [31:0] ex, ey, et, px, py, sex, sey, set;
        logic signed [30:0] pt;
    } residual_t;

    logic clk, rst_n, start, busy, done, cfg_we;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic signed [31:0] odom_x, odom_y, scan_x, scan_y;
    logic signed [30:0] odom_yaw, scan_yaw;
    logic signed [31:0] err_x, err_y, err_yaw, pred_x, pred_y;
    logic signed [31:0] scan_err_x, scan_err_y, scan_err_yaw;
    logic signed [30:0] pred_yaw;

    longint ext_x_m, ext_y_m, ext_yaw_m;
    residual_t residual_q[$];
    int  mismatches;
    int  cycles;
    bit  idle_on;

    planar_pose_residual i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .odom_x(odom_x), .odom_y(odom_y), .odom_yaw(odom_yaw),
        .scan_x(scan_x), .scan_y(scan_y), .scan_yaw(scan_yaw),
        .err_x(err_x), .err_y(err_y), .err_yaw(err_yaw),
        .pred_x(pred_x), .pred_y(pred_y), .pred_yaw(pred_yaw),
        .scan_err_x(scan_err_x), .scan_err_y(scan_err_y),
        .scan_err_yaw(scan_err_yaw)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // product / 2^30, nearest, ties away from zero
    function automatic longint mul_q30(input longint a, input longint b);
        longint p;
        begin
            p = a * b;
            if (p >= 0)
                mul_q30 = (p + (64'sd1 <<< 29)) >>> 30;
            else
                mul_q30 = -((-p + (64'sd1 <<< 29)) >>> 30);
        end
    endfunction

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        begin
            hi = (64'sd1 <<< (w - 1)) - 1;
            clamp = (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
        end
    endfunction

    task automatic sin_cos(input longint ang, output longint sn, output longint cs);
        longint sdiv[5], cdiv[6];
        longint a, n, q, r, x2, s, c;
        begin
            sdiv = '{110, 72, 42, 20, 6};
            cdiv = '{132, 90, 56, 30, 12, 2};
            a = ang * (64'sd1 <<< (30 - AFB));
            n = a + (HALF_PI_FX >>> 1);
            q = n / HALF_PI_FX;
            if (n % HALF_PI_FX < 0)
                q = q - 1;
            r = a - q * HALF_PI_FX;
            x2 = mul_q30(r, r);
            s = 64'sd1 <<< 30;
            for (int i = 0; i < 5; i++)
                s = (64'sd1 <<< 30) - mul_q30(x2, s) / sdiv[i];
            s = mul_q30(r, s);
            c = 64'sd1 <<< 30;
            for (int i = 0; i < 6; i++)
                c = (64'sd1 <<< 30) - mul_q30(x2, c) / cdiv[i];
            case (q[1:0])
                QUAD_0: begin sn = s;  cs = c;  end
                QUAD_1: begin sn = c;  cs = -s; end
                QUAD_2: begin sn = -s; cs = -c; end
                default: begin sn = -c; cs = s; end
            endcase
        end
    endtask

    function automatic longint wrap_angle(input longint t);
        longint pi_a, tp;
        begin
            pi_a = (PI_FX + (64'sd1 <<< (29 - AFB))) >>> (30 - AFB);
            tp = (TWO_PI_FX + (64'sd1 <<< (29 - AFB))) >>> (30 - AFB);
            if (t > pi_a)
                t = t - ((t - pi_a + tp - 1) / tp) * tp;
            else if (t < -pi_a)
                t = t + ((-pi_a - t + tp - 1) / tp) * tp;
            wrap_angle = t;
        end
    endfunction

    task automatic predict_residual(input pose_pair_t p, output residual_t e);
        longint ox, oy, ot, sx, sy, st;
        longint sl, cl, so, co, lsx, lsy, olx, oly, px, py, pt;
        begin
            ox = p.ox; oy = p.oy; ot = p.ot; sx = p.sx; sy = p.sy; st = p.st;
            sin_cos(ext_yaw_m, sl, cl);
            sin_cos(ot, so, co);
            lsx = ext_x_m + mul_q30(cl, sx) - mul_q30(sl, sy);
            lsy = ext_y_m + mul_q30(sl, sx) + mul_q30(cl, sy);
            olx = ox + mul_q30(co, ext_x_m) - mul_q30(so, ext_y_m);
            oly = oy + mul_q30(so, ext_x_m) + mul_q30(co, ext_y_m);
            px = -(mul_q30(cl, ext_x_m) + mul_q30(sl, ext_y_m))
                 + mul_q30(cl, olx) + mul_q30(sl, oly);
            py = (mul_q30(sl, ext_x_m) - mul_q30(cl, ext_y_m))
                 - mul_q30(sl, olx) + mul_q30(cl, oly);
            pt = clamp(wrap_angle(ot), 31);
            e.ex  = 32'(clamp(lsx - olx, 32));
            e.ey  = 32'(clamp(lsy - oly, 32));
            e.et  = 32'(clamp(st - ot, 32));
            e.px  = 32'(clamp(px, 32));
            e.py  = 32'(clamp(py, 32));
            e.pt  = 31'(pt);
            e.sex = 32'(clamp(px - sx, 32));
            e.sey = 32'(clamp(py - sy, 32));
            e.set = 32'(clamp(pt - st, 32));
        end
    endtask

    task automatic report_mismatch(input string fld, input longint got, input longint want);
        begin
            $display("MISMATCH %s: got %0d expected %0d at %0t", fld, got, want, $realtime);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        residual_t e;
        if (rst_n && done)
        begin
            if (residual_q.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                e = residual_q.pop_front();
                if (err_x != e.ex) report_mismatch("err_x", err_x, e.ex);
                if (err_y != e.ey) report_mismatch("err_y", err_y, e.ey);
                if (err_yaw != e.et) report_mismatch("err_yaw", err_yaw, e.et);
                if (pred_x != e.px) report_mismatch("pred_x", pred_x, e.px);
                if (pred_y != e.py) report_mismatch("pred_y", pred_y, e.py);
                if (pred_yaw != e.pt) report_mismatch("pred_yaw", pred_yaw, e.pt);
                if (scan_err_x != e.sex) report_mismatch("scan_err_x", scan_err_x, e.sex);
                if (scan_err_y != e.sey) report_mismatch("scan_err_y", scan_err_y, e.sey);
                if (scan_err_yaw != e.set)
                    report_mismatch("scan_err_yaw", scan_err_yaw, e.set);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // one beat; start stays high when the next beat follows directly
    task automatic send_pose(input pose_pair_t p);
        residual_t e;
        begin
            odom_x <= p.ox; odom_y <= p.oy; odom_yaw <= p.ot;
            scan_x <= p.sx; scan_y <= p.sy; scan_yaw <= p.st;
            start <= 1'b1;
            do
                @(posedge clk);
            while (busy);
            predict_residual(p, e);
            residual_q = {residual_q, e};
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (residual_q.size() != 0)
                @(posedge clk);
            repeat (DRAIN) @(posedge clk);
        end
    endtask

    // write enable stays high across back-to-back writes; caller drops it
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        begin
            cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
            @(posedge clk);
            case (idx)
                REG_EXT_X:   ext_x_m = longint'($signed(val));
                REG_EXT_Y:   ext_y_m = longint'($signed(val));
                REG_EXT_YAW: ext_yaw_m = longint'($signed(val[30:0]));
                default: ;
            endcase
        end
    endtask

    task automatic set_extrinsic(input logic [31:0] x, input logic [31:0] y,
                                 input logic [30:0] t);
        begin
            drain();
            write_reg(REG_EXT_X, x);
            write_reg(REG_EXT_Y, y);
            write_reg(REG_EXT_YAW, {1'b0, t});
            cfg_we <= 1'b0;
        end
    endtask

    function automatic logic [30:0] rand_yaw();
        begin
            if ($urandom_range(0, 3) == 0)
                rand_yaw = 31'($urandom);
            else
                rand_yaw = 31'(int'($urandom_range(0, 2 * YAW_MAX)) - YAW_MAX);
        end
    endfunction

    function automatic logic [31:0] rand_pos();
        begin
            case ($urandom_range(0, 3))
                0: rand_pos = $urandom;
                1: rand_pos = 32'(int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
                2: rand_pos = 32'(int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
                default: rand_pos = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 255)
                                                         : 32'h8000_0000 + $urandom_range(0, 255);
            endcase
        end
    endfunction

    function automatic pose_pair_t rand_pair();
        pose_pair_t p;
        begin
            p.ox = rand_pos(); p.oy = rand_pos(); p.ot = rand_yaw();
            p.sx = rand_pos(); p.sy = rand_pos(); p.st = rand_yaw();
            rand_pair = p;
        end
    endfunction

    function automatic pose_pair_t mk_pair(input logic [31:0] ox, input logic [31:0] oy,
                                           input logic [30:0] ot, input logic [31:0] sx,
                                           input logic [31:0] sy, input logic [30:0] st);
        pose_pair_t p;
        begin
            p.ox = ox; p.oy = oy; p.ot = ot; p.sx = sx; p.sy = sy; p.st = st;
            mk_pair = p;
        end
    endfunction

    // field extremes, yaw at and beyond +-pi, quadrant boundaries
    task automatic test_directed();
        logic [30:0] yaws[10];
        begin
            yaws = '{31'd0, 31'(YAW_MAX), 31'(-YAW_MAX), 31'(YAW_MAX + 1),
                     31'(-YAW_MAX - 1), 31'h3fff_ffff, 31'h4000_0000,
                     31'd421657428, 31'(-421657428), 31'd210828714};
            send_pose(mk_pair(0, 0, 0, 0, 0, 0));
            foreach (yaws[i])
                send_pose(mk_pair(32'h0001_0000, 32'hffff_0000, yaws[i],
                                  32'h0002_0000, 32'h0000_8000, yaws[9 - i]));
            send_pose(mk_pair(32'h7fff_ffff, 32'h7fff_ffff, 31'(YAW_MAX),
                              32'h8000_0000, 32'h8000_0000, 31'(-YAW_MAX)));
            send_pose(mk_pair(32'h8000_0000, 32'h8000_0000, 31'h4000_0000,
                              32'h7fff_ffff, 32'h7fff_ffff, 31'h3fff_ffff));
            send_pose(mk_pair(32'hffff_ffff, 32'h1, 31'h7fff_ffff, 32'h1, 32'hffff_ffff, 31'h1));
        end
    endtask

    task automatic test_extrinsic_extremes();
        begin
            set_extrinsic(32'h7fff_ffff, 32'h8000_0000, 31'(YAW_MAX));
            test_directed();
            set_extrinsic(32'h8000_0000, 32'h7fff_ffff, 31'(-YAW_MAX));
            test_directed();
            set_extrinsic(32'h0000_8000, 32'hfffe_0000, 31'h4000_0000);
            test_directed();
        end
    endtask

    task automatic test_random_poses(input int n_phases, input int per_phase);
        begin
            for (int ph = 0; ph < n_phases; ph++)
            begin
                if (ph % 2 == 0)
                    set_extrinsic(rand_pos(), rand_pos(), rand_yaw());
                else
                    set_extrinsic(32'(int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000),
                                  32'(int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000),
                                  rand_yaw());
                repeat (per_phase) send_pose(rand_pair());
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        odom_x = '0; odom_y = '0; odom_yaw = '0; scan_x = '0; scan_y = '0; scan_yaw = '0;
        ext_x_m = 0; ext_y_m = 0; ext_yaw_m = 0;
        mismatches = 0; cycles = 0; idle_on = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_extrinsic_extremes();
        test_random_poses(12, 140);
        idle_on = 1'b0;
        test_random_poses(2, 80);
        drain();

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/ppr_pkg.sv
design/ppr_cell.sv
design/planar_pose_residual.sv
tb/testbench.sv
